/* sv/crcfr_pkg.sv */
// Shared constants, types and the CRC-8 step for the checked frame receiver.
`timescale 1ns / 1ps
package crcfr_pkg;

  localparam int MAX_FRAME = 64;
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  localparam int LEN_W     = $clog2(MAX_FRAME + 1);
  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] MIN_LEN  = 8'd2;
  localparam logic [7:0] MAX_LEN  = 8'(MAX_FRAME - 2);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [1:0] {
    STAT_FRAME    = 2'd0,
    STAT_LEN_ERR  = 2'd1,
    STAT_OVERFLOW = 2'd2,
    STAT_CRC_ERR  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_RECV   = 2'b01,
    ST_REPLAY = 2'b10
  } state_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* sv/crcfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/crcfr_ctrl.sv */
// Deframer control: length and CRC checks, counters, frame replay and output register.
`timescale 1ns / 1ps
module crcfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_in,
  input  logic [31:0]          now_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [7:0]           frame_byte,
  output logic                 last,
  output logic [7:0]           frame_type,
  output crcfr_pkg::len_t      frame_length,
  output logic [31:0]          valid_count,
  output logic [31:0]          crc_error_count,
  output logic [31:0]          length_error_count,
  output logic [31:0]          overflow_count,
  output logic [31:0]          last_valid_time,
  output logic                 mem_we,
  output crcfr_pkg::addr_t     mem_waddr,
  output logic [7:0]           mem_wdata,
  output crcfr_pkg::addr_t     mem_raddr,
  input  logic [7:0]           mem_rdata
);

  import crcfr_pkg::*;

  state_t     state, state_next;
  len_t       pos, pos_next;
  len_t       exp_len, exp_len_next;
  logic [7:0] crc, crc_next;
  logic [7:0] type_hold, type_hold_next;
  len_t       rep_len, rep_len_next;
  addr_t      rd_addr, rd_addr_next;
  logic [31:0] valid_total, valid_total_next;
  logic [31:0] crc_err_total, crc_err_total_next;
  logic [31:0] len_err_total, len_err_total_next;
  logic [31:0] ovf_total, ovf_total_next;
  logic [31:0] good_time, good_time_next;
  logic [7:0]  good_type, good_type_next;
  logic        ov, ov_next;
  status_t     ost, ost_next;
  logic [7:0]  obyte, obyte_next;
  logic        olast, olast_next;
  len_t        olen, olen_next;
  logic        out_free, accept;
  len_t        pos_inc;
  logic        rep_last;

  assign out_free = !ov || out_ready;
  assign in_ready = (state == ST_RECV) && out_free;
  assign accept   = in_valid && in_ready;
  assign pos_inc  = pos + len_t'(1);
  assign rep_last = rd_addr == addr_t'(rep_len - len_t'(1));

  always_comb begin
    state_next         = state;
    pos_next           = pos;
    exp_len_next       = exp_len;
    crc_next           = crc;
    type_hold_next     = type_hold;
    rep_len_next       = rep_len;
    rd_addr_next       = rd_addr;
    valid_total_next   = valid_total;
    crc_err_total_next = crc_err_total;
    len_err_total_next = len_err_total;
    ovf_total_next     = ovf_total;
    good_time_next     = good_time;
    good_type_next     = good_type;
    ov_next            = ov && !out_ready;
    ost_next           = ost;
    obyte_next         = obyte;
    olast_next         = olast;
    olen_next          = olen;
    mem_we             = 1'b0;
    mem_waddr          = pos[ADDR_W-1:0];
    mem_wdata          = data_in;
    case (state)
      ST_RECV: begin
        if (accept) begin
          if (pos == len_t'(0)) begin
            mem_we   = 1'b1;
            pos_next = len_t'(1);
            crc_next = 8'd0;
          end else if (pos == len_t'(1)) begin
            if (data_in < MIN_LEN || data_in > MAX_LEN) begin
              len_err_total_next = len_err_total + 32'd1;
              pos_next     = '0;
              exp_len_next = '0;
              crc_next     = 8'd0;
              ov_next      = 1'b1;
              ost_next     = STAT_LEN_ERR;
              obyte_next   = 8'd0;
              olast_next   = 1'b1;
              olen_next    = '0;
            end else begin
              mem_we       = 1'b1;
              pos_next     = len_t'(2);
              exp_len_next = len_t'(data_in) + len_t'(2);
            end
          end else if (pos >= len_t'(MAX_FRAME)) begin
            ovf_total_next = ovf_total + 32'd1;
            pos_next     = '0;
            exp_len_next = '0;
            crc_next     = 8'd0;
            ov_next      = 1'b1;
            ost_next     = STAT_OVERFLOW;
            obyte_next   = 8'd0;
            olast_next   = 1'b1;
            olen_next    = '0;
          end else begin
            mem_we   = 1'b1;
            pos_next = pos_inc;
            if (pos == len_t'(2)) begin
              type_hold_next = data_in;
            end
            if (pos_inc < exp_len) begin
              crc_next = crc_fold(crc, data_in);
            end else if (data_in != crc) begin
              crc_err_total_next = crc_err_total + 32'd1;
              pos_next     = '0;
              exp_len_next = '0;
              crc_next     = 8'd0;
              ov_next      = 1'b1;
              ost_next     = STAT_CRC_ERR;
              obyte_next   = 8'd0;
              olast_next   = 1'b1;
              olen_next    = '0;
            end else begin
              valid_total_next = valid_total + 32'd1;
              good_time_next   = now_time;
              good_type_next   = type_hold;
              rep_len_next     = exp_len;
              rd_addr_next     = '0;
              pos_next         = '0;
              exp_len_next     = '0;
              crc_next         = 8'd0;
              state_next       = ST_REPLAY;
            end
          end
        end
      end
      ST_REPLAY: begin
        if (out_free) begin
          ov_next    = 1'b1;
          ost_next   = STAT_FRAME;
          obyte_next = mem_rdata;
          olast_next = rep_last;
          olen_next  = rep_len;
          if (rep_last) begin
            rd_addr_next = '0;
            state_next   = ST_RECV;
          end else begin
            rd_addr_next = rd_addr + addr_t'(1);
          end
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

  assign mem_raddr = rd_addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RECV;
      pos           <= '0;
      exp_len       <= '0;
      crc           <= 8'd0;
      rd_addr       <= '0;
      valid_total   <= 32'd0;
      crc_err_total <= 32'd0;
      len_err_total <= 32'd0;
      ovf_total     <= 32'd0;
      good_time     <= 32'd0;
      good_type     <= 8'd0;
      ov            <= 1'b0;
    end else begin
      state         <= state_next;
      pos           <= pos_next;
      exp_len       <= exp_len_next;
      crc           <= crc_next;
      rd_addr       <= rd_addr_next;
      valid_total   <= valid_total_next;
      crc_err_total <= crc_err_total_next;
      len_err_total <= len_err_total_next;
      ovf_total     <= ovf_total_next;
      good_time     <= good_time_next;
      good_type     <= good_type_next;
      ov            <= ov_next;
    end
    type_hold <= type_hold_next;
    rep_len   <= rep_len_next;
    ost       <= ost_next;
    obyte     <= obyte_next;
    olast     <= olast_next;
    olen      <= olen_next;
  end

  assign out_valid          = ov;
  assign status             = ost;
  assign frame_byte         = obyte;
  assign last               = olast;
  assign frame_length       = olen;
  assign frame_type         = good_type;
  assign valid_count        = valid_total;
  assign crc_error_count    = crc_err_total;
  assign length_error_count = len_err_total;
  assign overflow_count     = ovf_total;
  assign last_valid_time    = good_time;

endmodule

/* sv/crc_checked_frame_receiver.sv */
// Top level of the CRC-checked frame receiver: frame store RAM and deframer control.
// Input channel (in_valid/in_ready) carries one link byte and its arrival timestamp per
// transaction. Frames are address, length L (2..MAX_FRAME-2), type, payload and a CRC-8
// (polynomial 0xD5, init 0) over type and payload; a frame holds L+2 bytes.
// Output channel (out_valid/out_ready) gives one transaction per frame byte for a good
// frame, with last on its final byte, or a single status transaction for a length error,
// overflow or CRC error. Counters, last frame type and time ride on every transaction.
// Throughput: one input byte per cycle while the output register is free. When the final
// byte of a good frame is taken, input stops and the frame store RAM is read back at one
// byte per cycle while the output is not stalled; input resumes after the last byte is read.
// The first replayed byte passes through the RAM read register, then the output register;
// status results appear in the cycle after the byte that caused them.
// A stalled output holds its transaction and holds off input; nothing is dropped.
// Reset (rst, synchronous) clears the frame position, CRC, counters and output valid;
// the frame store needs no clearing since every byte replayed is written first.
`timescale 1ns / 1ps
module crc_checked_frame_receiver (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_in,
  input  logic [31:0]          now_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [7:0]           frame_byte,
  output logic                 last,
  output logic [7:0]           frame_type,
  output crcfr_pkg::len_t      frame_length,
  output logic [31:0]          valid_count,
  output logic [31:0]          crc_error_count,
  output logic [31:0]          length_error_count,
  output logic [31:0]          overflow_count,
  output logic [31:0]          last_valid_time
);

  import crcfr_pkg::*;

  logic       mem_we;
  addr_t      mem_waddr;
  addr_t      mem_raddr;
  logic [7:0] mem_wdata;
  logic [7:0] mem_rdata;

  crcfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  crcfr_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .data_in           (data_in),
    .now_time          (now_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .frame_byte        (frame_byte),
    .last              (last),
    .frame_type        (frame_type),
    .frame_length      (frame_length),
    .valid_count       (valid_count),
    .crc_error_count   (crc_error_count),
    .length_error_count(length_error_count),
    .overflow_count    (overflow_count),
    .last_valid_time   (last_valid_time),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata)
  );

`ifndef NO_ASSERTIONS
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_FRAME |-> last && frame_byte == 8'd0)
    else $error("status transaction without last");

  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FRAME |->
      frame_length >= len_t'(4) && frame_length <= len_t'(MAX_FRAME))
    else $error("replayed frame length out of range");

  a_no_input_stall: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken while output is stalled");

  a_valid_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> valid_count == $past(valid_count) ||
      valid_count == $past(valid_count) + 32'd1)
    else $error("valid count jumped");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for crc_checked_frame_receiver: directed and random link traffic.
`timescale 1ns / 1ps
module testbench;
  import crcfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TARGET_ITEMS   = 310;

  typedef enum logic [1:0] {
    RDY_ALWAYS   = 2'd0,
    RDY_COIN     = 2'd1,
    RDY_PERIODIC = 2'd2,
    RDY_SPARSE   = 2'd3
  } ready_mode_t;

  typedef struct {
    status_t     status;
    logic [7:0]  byte_val;
    logic        last;
    logic [7:0]  ftype;
    len_t        flen;
    logic [31:0] n_valid;
    logic [31:0] n_crc_err;
    logic [31:0] n_len_err;
    logic [31:0] n_ovf;
    logic [31:0] t_valid;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_in = 8'h00;
  logic [31:0] now_time = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  frame_byte;
  logic        last;
  logic [7:0]  frame_type;
  len_t        frame_length;
  logic [31:0] valid_count;
  logic [31:0] crc_error_count;
  logic [31:0] length_error_count;
  logic [31:0] overflow_count;
  logic [31:0] last_valid_time;

  // deframer state as seen by the predictor
  logic [7:0]  rx_store [0:63];
  int unsigned rx_pos = 0;
  int unsigned rx_len = 0;
  logic [7:0]  rx_crc = 8'h00;
  logic [31:0] cnt_valid = 0;
  logic [31:0] cnt_crc_err = 0;
  logic [31:0] cnt_len_err = 0;
  logic [31:0] cnt_ovf = 0;
  logic [31:0] good_time = 0;
  logic [7:0]  good_type = 8'h00;

  rx_item_t    pending_rx[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_span = 0;
  logic [7:0]  tick = 8'h00;

  crc_checked_frame_receiver dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .data_in            (data_in),
    .now_time           (now_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .frame_byte         (frame_byte),
    .last               (last),
    .frame_type         (frame_type),
    .frame_length       (frame_length),
    .valid_count        (valid_count),
    .crc_error_count    (crc_error_count),
    .length_error_count (length_error_count),
    .overflow_count     (overflow_count),
    .last_valid_time    (last_valid_time)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ b[k];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic void push_rx(status_t s, logic [7:0] b, logic lst, len_t n);
    rx_item_t r;
    r.status    = s;
    r.byte_val  = b;
    r.last      = lst;
    r.ftype     = good_type;
    r.flen      = n;
    r.n_valid   = cnt_valid;
    r.n_crc_err = cnt_crc_err;
    r.n_len_err = cnt_len_err;
    r.n_ovf     = cnt_ovf;
    r.t_valid   = good_time;
    pending_rx.push_back(r);
  endfunction

  function automatic void frame_restart();
    rx_pos = 0;
    rx_len = 0;
    rx_crc = 8'h00;
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic [31:0] t);
    if (rx_pos == 0) begin
      rx_store[0] = b;
      rx_pos = 1;
      rx_crc = 8'h00;
      return;
    end
    if (rx_pos == 1) begin
      if (b < MIN_LEN || b > MAX_LEN) begin
        cnt_len_err++;
        frame_restart();
        push_rx(STAT_LEN_ERR, 8'h00, 1'b1, '0);
        return;
      end
      rx_store[1] = b;
      rx_pos = 2;
      rx_len = b + 2;
      return;
    end
    if (rx_pos >= MAX_FRAME) begin
      cnt_ovf++;
      frame_restart();
      push_rx(STAT_OVERFLOW, 8'h00, 1'b1, '0);
      return;
    end
    rx_store[rx_pos] = b;
    if (rx_pos + 1 < rx_len) rx_crc = crc8_next(rx_crc, b);
    rx_pos++;
    if (rx_pos < rx_len) return;
    if (b != rx_crc) begin
      cnt_crc_err++;
      frame_restart();
      push_rx(STAT_CRC_ERR, 8'h00, 1'b1, '0);
      return;
    end
    cnt_valid++;
    good_time = t;
    good_type = rx_store[2];
    for (int i = 0; i < rx_len; i++) begin
      push_rx(STAT_FRAME, rx_store[i], (i + 1 == rx_len), len_t'(rx_len));
    end
    frame_restart();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    rx_item_t r;
    if (pending_rx.size() == 0) begin
      report_mismatch("unexpected transaction, byte", frame_byte, 0);
      return;
    end
    r = pending_rx.pop_front();
    if (status !== r.status) report_mismatch("status", status, r.status);
    if (frame_byte !== r.byte_val) report_mismatch("frame_byte", frame_byte, r.byte_val);
    if (last !== r.last) report_mismatch("last", last, r.last);
    if (frame_type !== r.ftype) report_mismatch("frame_type", frame_type, r.ftype);
    if (frame_length !== r.flen) report_mismatch("frame_length", frame_length, r.flen);
    if (valid_count !== r.n_valid) report_mismatch("valid_count", valid_count, r.n_valid);
    if (crc_error_count !== r.n_crc_err)
      report_mismatch("crc_error_count", crc_error_count, r.n_crc_err);
    if (length_error_count !== r.n_len_err)
      report_mismatch("length_error_count", length_error_count, r.n_len_err);
    if (overflow_count !== r.n_ovf) report_mismatch("overflow_count", overflow_count, r.n_ovf);
    if (last_valid_time !== r.t_valid)
      report_mismatch("last_valid_time", last_valid_time, r.t_valid);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_span <= $urandom_range(16, 160);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      RDY_ALWAYS:   out_ready <= 1'b1;
      RDY_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RDY_PERIODIC: out_ready <= (tick[1:0] != 2'b11);
      default:      out_ready <= ($urandom_range(0, 7) == 0);
    endcase
    tick <= tick + 8'd1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    data_in  <= b;
    now_time <= t;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    deframe_byte(b, t);
  endtask

  task automatic send_frame(input logic [7:0] addr, input int unsigned len,
                            input bit bad_crc, input logic [31:0] t_last);
    logic [7:0] acc;
    logic [7:0] b;
    acc = 8'h00;
    send_byte(addr, $urandom());
    send_byte(8'(len), $urandom());
    for (int i = 0; i < len - 1; i++) begin
      b = 8'($urandom());
      acc = crc8_next(acc, b);
      send_byte(b, $urandom());
    end
    if (bad_crc) acc ^= 8'($urandom_range(1, 255));
    send_byte(acc, t_last);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rx.size() != 0) @(posedge clk);
  endtask

  task automatic test_length_limits();
    send_byte(8'h00, 32'h0);
    send_byte(8'h00, 32'hFFFF_FFFF);
    send_byte(8'hFF, 32'h0);
    send_byte(8'h01, 32'h0);
    send_byte(8'h5A, 32'h1234_5678);
    send_byte(8'(MAX_LEN + 1), 32'h0);
    send_byte(8'hA5, 32'h0);
    send_byte(8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_short_frames();
    send_frame(8'h00, MIN_LEN, 1'b0, 32'h0);
    send_frame(8'hFF, MIN_LEN, 1'b1, 32'hFFFF_FFFF);
    send_frame(8'hC8, 3, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_longest_frames();
    send_frame(8'($urandom()), MAX_LEN, 1'b0, $urandom());
    send_frame(8'($urandom()), MAX_LEN, 1'b1, $urandom());
  endtask

  task automatic test_drain_pause();
    send_frame(8'($urandom()), $urandom_range(2, 8), 1'b0, $urandom());
    wait_drained();
    send_frame(8'($urandom()), $urandom_range(2, 8), 1'b0, $urandom());
  endtask

  task automatic test_random_traffic();
    int pick;
    int unsigned n;
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(8'($urandom()), $urandom_range(2, 12), 1'b0, $urandom());
      end else if (pick < 67) begin
        send_frame(8'($urandom()), MAX_LEN, 1'b0, $urandom());
      end else if (pick < 80) begin
        send_frame(8'($urandom()), $urandom_range(2, 12), 1'b1, $urandom());
      end else if (pick < 90) begin
        send_byte(8'($urandom()), $urandom());
        if ($urandom_range(0, 1) == 0) begin
          send_byte(8'($urandom_range(0, 1)), $urandom());
        end else begin
          send_byte(8'($urandom_range(MAX_LEN + 1, 255)), $urandom());
        end
      end else begin
        // truncate a frame, then push filler until the deframer resyncs
        n = $urandom_range(2, 12);
        send_byte(8'($urandom()), $urandom());
        send_byte(8'(n), $urandom());
        repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom()), $urandom());
        while (rx_pos != 0) send_byte(8'($urandom()), $urandom());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_length_limits();
    test_short_frames();
    test_longest_frames();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
